### rtl/sht_cut_pkg.sv
// Shared constants, codes and types of the strip hit timing cut block.
`default_nettype none

package sht_cut_pkg;

    localparam int MAX_HITS_DEF  = 64;
    localparam int DETECTORS_DEF = 16;
    localparam int STRIPS_DEF    = 64;

    localparam int CUT_WORDS = 6;
    localparam int TIME_W    = 26;
    localparam int WORD_W    = 24;
    localparam int GAIN_W    = 16;
    localparam int TAC_W     = 14;
    localparam int PROD_W    = TAC_W + GAIN_W;
    localparam int CMP_W     = TIME_W + 2;
    localparam int S_DATA_W  = 56;
    localparam int M_DATA_W  = 40;

    localparam logic [1:0] FUNC_HIT = 2'd0;
    localparam logic [1:0] FUNC_CAL = 2'd1;
    localparam logic [1:0] FUNC_CUT = 2'd2;

    localparam logic [1:0] ST_PASS   = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_NO_CAL = 2'd2;
    localparam logic [1:0] ST_NO_CUT = 2'd3;

    localparam logic [2:0] CAL_GAIN   = 3'd0;
    localparam logic [2:0] CAL_OFFSET = 3'd1;

    localparam logic [2:0] CUT_SHAPING  = 3'd0;
    localparam logic [2:0] CUT_WINDOW   = 3'd1;
    localparam logic [2:0] CUT_DISABLE  = 3'd2;
    localparam logic [2:0] CUT_FLAG_EN  = 3'd3;
    localparam logic [2:0] CUT_NOISE    = 3'd4;
    localparam logic [2:0] CUT_FLAG_DLY = 3'd5;

    typedef struct packed {
        logic [3:0]               det;
        logic                     side;
        logic [5:0]               strip;
        logic signed [TIME_W-1:0] hit_time;
        logic                     cal;
        logic                     guard;
        logic                     fast;
        logic                     nn;
    } hit_t;

    typedef logic [CUT_WORDS-1:0][WORD_W-1:0] cut_row_t;

endpackage

`default_nettype wire

### rtl/strip_hit_timing_cut.sv
// Strip hit timing cut: table-driven hit calibration, buffering and event judging.
// After reset the block sweeps its calibration and cut valid bits, one entry per
// cycle, over all DETECTORS*2*STRIPS entries with s_tready low. A hit passes
// through valid/table read, gain multiply, then time add and buffer write. At the
// end of an event the hit buffer is walked one buffered hit at a time (buffer read,
// cut table read, cut sums, compares, emit) before the final beat; a rejected event
// gives its single beat.
// The buffer memory and the cut table read port set the judging rate.
`default_nettype none

module strip_hit_timing_cut #(
    parameter int MAX_HITS  = sht_cut_pkg::MAX_HITS_DEF,
    parameter int DETECTORS = sht_cut_pkg::DETECTORS_DEF,
    parameter int STRIPS    = sht_cut_pkg::STRIPS_DEF
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // detector, side, strip, tac, guard_ring, fast_timing, nearest_neighbour,
    // word_select, word_value
    input  wire logic [sht_cut_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic [1:0]                       s_tuser, // func
    input  wire logic                             s_tlast,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // status, out_detector, out_side, out_strip, hit_time, time_calibrated
    output logic [sht_cut_pkg::M_DATA_W-1:0]      m_tdata,
    output logic                                  m_tlast
);

    localparam int ENTRIES = DETECTORS * 2 * STRIPS;
    localparam int EAW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int HAW     = (MAX_HITS > 1) ? $clog2(MAX_HITS) : 1;
    localparam int HCW     = $clog2(MAX_HITS + 1);
    localparam int TW      = sht_cut_pkg::TIME_W;
    localparam int CW      = sht_cut_pkg::CMP_W;
    localparam int WW      = sht_cut_pkg::WORD_W;

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_HIT_A = 4'd2;
    localparam logic [3:0] S_HIT_B = 4'd3;
    localparam logic [3:0] S_ERR   = 4'd4;
    localparam logic [3:0] S_J_BUF = 4'd5;
    localparam logic [3:0] S_J_CUT = 4'd6;
    localparam logic [3:0] S_J_SUM = 4'd7;
    localparam logic [3:0] S_J_CMP = 4'd8;
    localparam logic [3:0] S_J_PUT = 4'd9;
    localparam logic [3:0] S_J_END = 4'd10;

    function automatic logic [EAW-1:0] entry_of(input logic [3:0] d, input logic s,
                                                input logic [5:0] st);
        logic [31:0] f;
        logic        ok;
        f  = ((32'(d) << 1) + 32'(s)) * 32'(STRIPS) + 32'(st);
        ok = (32'(d) < 32'(DETECTORS)) && (32'(st) < 32'(STRIPS));
        entry_of = ok ? f[EAW-1:0] : '0;
    endfunction

    // input beat fields
    logic [3:0]          in_det;
    logic                in_side;
    logic [5:0]          in_strip;
    logic [13:0]         in_tac;
    logic                in_guard, in_fast, in_nn;
    logic [2:0]          in_sel;
    logic signed [WW-1:0] in_val;
    logic                in_range;
    logic [EAW-1:0]      in_entry;
    logic                accept;
    logic                cal_wr, cut_wr;

    assign in_det   = s_tdata[3:0];
    assign in_side  = s_tdata[4];
    assign in_strip = s_tdata[10:5];
    assign in_tac   = s_tdata[24:11];
    assign in_guard = s_tdata[25];
    assign in_fast  = s_tdata[26];
    assign in_nn    = s_tdata[27];
    assign in_sel   = s_tdata[30:28];
    assign in_val   = s_tdata[54:31];
    assign in_range = (32'(in_det) < 32'(DETECTORS)) && (32'(in_strip) < 32'(STRIPS));
    assign in_entry = entry_of(in_det, in_side, in_strip);
    assign accept   = s_tvalid && s_tready;
    assign cal_wr   = accept && s_tuser == sht_cut_pkg::FUNC_CAL && in_range &&
                      (in_sel == sht_cut_pkg::CAL_GAIN || in_sel == sht_cut_pkg::CAL_OFFSET);
    assign cut_wr   = accept && s_tuser == sht_cut_pkg::FUNC_CUT && in_range &&
                      32'(in_sel) < 32'(sht_cut_pkg::CUT_WORDS);

    // control registers
    logic [3:0]           state_reg, state_next;
    logic [EAW-1:0]       clr_reg, clr_next;
    logic [HCW-1:0]       count_reg, count_next;
    logic [HCW-1:0]       idx_reg, idx_next;
    logic signed [TW-1:0] latest_reg, latest_next;
    logic                 seen_reg, seen_next;
    logic [1:0]           err_reg, err_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic                 m_tvalid_reg, m_tvalid_next;

    // payload registers
    logic [3:0]           det_reg;
    logic                 side_reg;
    logic [5:0]           strip_reg;
    logic [13:0]          tac_reg;
    logic                 guard_reg, fast_reg, nn_reg, last_reg, range_reg;
    logic [sht_cut_pkg::PROD_W-1:0] prod_reg, prod_next;
    sht_cut_pkg::hit_t    cur_reg, cur_next;
    sht_cut_pkg::hit_t    pend_reg, pend_next;
    logic signed [CW-1:0] total_reg, total_next;
    logic signed [CW-1:0] low_reg, low_next;
    logic signed [CW-1:0] win_reg, win_next;
    logic signed [CW-1:0] floor_reg, floor_next;
    logic                 keep_reg, keep_next;
    logic [sht_cut_pkg::M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tlast_reg, m_tlast_next;

    // memories
    logic [sht_cut_pkg::GAIN_W-1:0] gain_mem   [ENTRIES];
    logic signed [WW-1:0]           offset_mem [ENTRIES];
    logic                           calv_mem   [ENTRIES];
    logic                           cutv_mem   [ENTRIES];
    sht_cut_pkg::cut_row_t          cut_mem    [ENTRIES];
    sht_cut_pkg::hit_t              hit_mem    [MAX_HITS];

    logic [sht_cut_pkg::GAIN_W-1:0] gain_q;
    logic signed [WW-1:0]           offset_q;
    logic                           calv_q, cutv_q;
    sht_cut_pkg::cut_row_t          cut_q;
    sht_cut_pkg::hit_t              hit_q;
    logic [EAW-1:0]                 cut_addr;

    logic                 hit_wr;
    sht_cut_pkg::hit_t    hit_w;
    logic                 out_free;
    logic                 hit_cal;
    logic signed [TW-1:0] hit_time_w;
    logic signed [CW-1:0] t_ext;
    logic                 drop_fast;

    assign cut_addr = entry_of(hit_q.det, hit_q.side, hit_q.strip);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = state_reg == S_IDLE;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    always_ff @(posedge aclk) begin
        if (cal_wr && in_sel == sht_cut_pkg::CAL_GAIN) begin
            gain_mem[in_entry] <= in_val[sht_cut_pkg::GAIN_W-1:0];
        end
        if (cal_wr && in_sel == sht_cut_pkg::CAL_OFFSET) begin
            offset_mem[in_entry] <= in_val;
        end
        if (accept) begin
            gain_q   <= gain_mem[in_entry];
            offset_q <= offset_mem[in_entry];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) begin
            calv_mem[clr_reg] <= 1'b0;
            cutv_mem[clr_reg] <= 1'b0;
        end else begin
            if (cal_wr) begin
                calv_mem[in_entry] <= 1'b1;
            end
            if (cut_wr) begin
                cutv_mem[in_entry] <= 1'b1;
            end
        end
        if (accept) begin
            calv_q <= calv_mem[in_entry];
            cutv_q <= cutv_mem[in_entry];
        end
    end

    always_ff @(posedge aclk) begin
        if (cut_wr) begin
            cut_mem[in_entry][in_sel] <= in_val;
        end
        cut_q <= cut_mem[cut_addr];
    end

    always_ff @(posedge aclk) begin
        if (hit_wr) begin
            hit_mem[count_reg[HAW-1:0]] <= hit_w;
        end
        hit_q <= hit_mem[idx_reg[HAW-1:0]];
    end

    always_comb begin
        hit_cal    = tac_reg != '0 && !guard_reg && range_reg;
        hit_time_w = hit_cal ?
            $signed({{(TW-sht_cut_pkg::PROD_W+8){1'b0}}, prod_reg[sht_cut_pkg::PROD_W-1:8]}) +
            TW'(offset_q) : '0;
        hit_w.det      = det_reg;
        hit_w.side     = side_reg;
        hit_w.strip    = strip_reg;
        hit_w.hit_time = hit_time_w;
        hit_w.cal      = hit_cal;
        hit_w.guard    = guard_reg;
        hit_w.fast     = fast_reg;
        hit_w.nn       = nn_reg;
        hit_wr = state_reg == S_HIT_B && 32'(count_reg) < 32'(MAX_HITS);
        t_ext  = CW'(cur_reg.hit_time);
        drop_fast = t_ext > total_reg + win_reg || t_ext < total_reg ||
                    (seen_reg && t_ext < low_reg);
    end

    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        latest_next     = latest_reg;
        seen_next       = seen_reg;
        err_next        = err_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        cur_next        = cur_reg;
        prod_next       = prod_reg;
        total_next      = total_reg;
        low_next        = low_reg;
        win_next        = win_reg;
        floor_next      = floor_reg;
        keep_next       = keep_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        m_tlast_next    = m_tlast_reg;

        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == EAW'(ENTRIES - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept && s_tuser == sht_cut_pkg::FUNC_HIT) begin
                    state_next = S_HIT_A;
                end
            end
            S_HIT_A: begin
                prod_next = tac_reg * gain_q;
                if (err_reg == '0) begin
                    if (32'(det_reg) >= 32'(DETECTORS)) begin
                        err_next = sht_cut_pkg::ST_NO_CAL;
                    end else if (!guard_reg && (!range_reg || !calv_q)) begin
                        err_next = sht_cut_pkg::ST_NO_CAL;
                    end else if (!guard_reg && !cutv_q) begin
                        err_next = sht_cut_pkg::ST_NO_CUT;
                    end
                end
                state_next = S_HIT_B;
            end
            S_HIT_B: begin
                if (hit_wr) begin
                    count_next = count_reg + 1'b1;
                    if (hit_cal && fast_reg && !nn_reg &&
                        (!seen_reg || hit_time_w > latest_reg)) begin
                        latest_next = hit_time_w;
                        seen_next   = 1'b1;
                    end
                end
                if (!last_reg) begin
                    state_next = S_IDLE;
                end else if (err_reg != '0) begin
                    state_next = S_ERR;
                end else begin
                    idx_next   = '0;
                    state_next = S_J_BUF;
                end
            end
            S_ERR: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(sht_cut_pkg::M_DATA_W-2){1'b0}}, err_reg};
                    m_tlast_next  = 1'b1;
                    count_next    = '0;
                    latest_next   = '0;
                    seen_next     = 1'b0;
                    err_next      = '0;
                    state_next    = S_IDLE;
                end
            end
            S_J_BUF: begin
                state_next = (idx_reg == count_reg) ? S_J_END : S_J_CUT;
            end
            S_J_CUT: begin
                cur_next   = hit_q;
                state_next = S_J_SUM;
            end
            S_J_SUM: begin
                total_next = CW'($signed(cut_q[sht_cut_pkg::CUT_SHAPING])) +
                             CW'($signed(cut_q[sht_cut_pkg::CUT_DISABLE])) +
                             CW'($signed(cut_q[sht_cut_pkg::CUT_FLAG_EN])) +
                             CW'($signed(cut_q[sht_cut_pkg::CUT_FLAG_DLY]));
                win_next   = CW'($signed(cut_q[sht_cut_pkg::CUT_WINDOW]));
                low_next   = CW'(latest_reg) - CW'($signed(cut_q[sht_cut_pkg::CUT_WINDOW]));
                floor_next = CW'($signed(cut_q[sht_cut_pkg::CUT_NOISE]));
                state_next = S_J_CMP;
            end
            S_J_CMP: begin
                keep_next  = !cur_reg.cal ||
                             !(t_ext < floor_reg || (cur_reg.fast && drop_fast));
                state_next = S_J_PUT;
            end
            S_J_PUT: begin
                if (!keep_reg) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = S_J_BUF;
                end else if (!pend_valid_reg) begin
                    pend_next       = cur_reg;
                    pend_valid_next = 1'b1;
                    idx_next        = idx_reg + 1'b1;
                    state_next      = S_J_BUF;
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {pend_reg.cal, pend_reg.hit_time, pend_reg.strip,
                                     pend_reg.side, pend_reg.det, sht_cut_pkg::ST_PASS};
                    m_tlast_next  = 1'b0;
                    pend_next     = cur_reg;
                    idx_next      = idx_reg + 1'b1;
                    state_next    = S_J_BUF;
                end
            end
            S_J_END: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tlast_next  = 1'b1;
                    if (pend_valid_reg) begin
                        m_tdata_next = {pend_reg.cal, pend_reg.hit_time, pend_reg.strip,
                                        pend_reg.side, pend_reg.det, sht_cut_pkg::ST_PASS};
                    end else begin
                        m_tdata_next = {{(sht_cut_pkg::M_DATA_W-2){1'b0}},
                                        sht_cut_pkg::ST_EMPTY};
                    end
                    pend_valid_next = 1'b0;
                    count_next      = '0;
                    latest_next     = '0;
                    seen_next       = 1'b0;
                    err_next        = '0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            latest_reg     <= '0;
            seen_reg       <= 1'b0;
            err_reg        <= '0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            latest_reg     <= latest_next;
            seen_reg       <= seen_next;
            err_reg        <= err_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            det_reg   <= in_det;
            side_reg  <= in_side;
            strip_reg <= in_strip;
            tac_reg   <= in_tac;
            guard_reg <= in_guard;
            fast_reg  <= in_fast;
            nn_reg    <= in_nn;
            last_reg  <= s_tlast;
            range_reg <= in_range;
        end
        prod_reg    <= prod_next;
        cur_reg     <= cur_next;
        pend_reg    <= pend_next;
        total_reg   <= total_next;
        low_reg     <= low_next;
        win_reg     <= win_next;
        floor_reg   <= floor_next;
        keep_reg    <= keep_next;
        m_tdata_reg <= m_tdata_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

`default_nettype wire

### rtl/sht_cut_chk.sv
// Port-level checker for the strip hit timing cut block, with its bind.
`default_nettype none

module sht_cut_chk (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [sht_cut_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic                             m_tlast
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != sht_cut_pkg::ST_PASS |-> m_tlast)
        else $error("status beat not last of event");

    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] != sht_cut_pkg::ST_PASS |-> m_tdata[39:2] == '0)
        else $error("status beat carries hit fields");

    a_uncal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == sht_cut_pkg::ST_PASS && !m_tdata[39]
        |-> m_tdata[38:13] == '0)
        else $error("uncalibrated hit with nonzero time");

endmodule

bind strip_hit_timing_cut sht_cut_chk u_sht_cut_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/testbench.sv
// Self-checking testbench for strip_hit_timing_cut: table writes, hit events, cut checks.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic [1:0]  func;
        logic [3:0]  det;
        logic        side;
        logic [5:0]  strip;
        logic [13:0] tac;
        logic        guard;
        logic        fast;
        logic        nn;
        logic        last;
        logic [2:0]  sel;
        logic [23:0] val;
        bit          hold;
    } item_t;

    typedef struct {
        logic [1:0]  status;
        logic [3:0]  det;
        logic        side;
        logic [5:0]  strip;
        logic [25:0] tm;
        logic        cal;
        logic        last;
    } outcome_t;

    typedef struct {
        logic [10:0] e;
        longint      tm;
        bit          cal, guard, fast, nn;
    } held_hit_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    strip_hit_timing_cut u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always #6 aclk = ~aclk;

    item_t     pending[$];
    outcome_t  expected_out[$];
    held_hit_t event_hits[$];
    int        errors = 0;
    int        cycles = 0;
    bit        quiet = 1'b0;

    logic [15:0] gain_mem[2048];
    int          offset_mem[2048];
    bit          cal_ok[2048];
    int          cut_mem[2048][6];
    bit          cut_ok[2048];
    longint      latest;
    bit          latest_seen;
    logic [1:0]  event_err;

    bit          gen_cal[2048];
    bit          gen_cut[2048];
    logic [10:0] full_pool[$];
    logic [10:0] cal_pool[$];

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH %s: got %0h expected %0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic bit hit_survives(held_hit_t h);
        longint tot, win;
        if (!h.cal || h.guard) return 1'b1;
        if (h.tm < longint'(cut_mem[h.e][sht_cut_pkg::CUT_NOISE])) return 1'b0;
        if (!h.fast) return 1'b1;
        tot = longint'(cut_mem[h.e][sht_cut_pkg::CUT_SHAPING])
            + cut_mem[h.e][sht_cut_pkg::CUT_DISABLE]
            + cut_mem[h.e][sht_cut_pkg::CUT_FLAG_EN]
            + cut_mem[h.e][sht_cut_pkg::CUT_FLAG_DLY];
        win = cut_mem[h.e][sht_cut_pkg::CUT_WINDOW];
        if (h.tm > tot + win || h.tm < tot) return 1'b0;
        if (latest_seen && h.tm < latest - win) return 1'b0;
        return 1'b1;
    endfunction

    task automatic predict_item(item_t b);
        logic [10:0] e;
        held_hit_t   h;
        outcome_t    o;
        int          n;
        e = {b.det, b.side, b.strip};
        case (b.func)
            sht_cut_pkg::FUNC_CAL: begin
                if (b.sel == sht_cut_pkg::CAL_GAIN) begin
                    gain_mem[e] = b.val[15:0];
                    cal_ok[e] = 1'b1;
                end else if (b.sel == sht_cut_pkg::CAL_OFFSET) begin
                    offset_mem[e] = $signed(b.val);
                    cal_ok[e] = 1'b1;
                end
            end
            sht_cut_pkg::FUNC_CUT: begin
                if (b.sel <= sht_cut_pkg::CUT_FLAG_DLY) begin
                    cut_mem[e][b.sel] = $signed(b.val);
                    cut_ok[e] = 1'b1;
                end
            end
            sht_cut_pkg::FUNC_HIT: begin
                if (event_err == 2'd0) begin
                    if (!b.guard && !cal_ok[e]) event_err = sht_cut_pkg::ST_NO_CAL;
                    else if (!b.guard && !cut_ok[e]) event_err = sht_cut_pkg::ST_NO_CUT;
                end
                if (event_hits.size() < 64) begin
                    h.e = e;
                    h.guard = b.guard;
                    h.fast = b.fast;
                    h.nn = b.nn;
                    h.cal = 1'b0;
                    h.tm = 0;
                    if (b.tac != 0 && !b.guard) begin
                        h.tm = ((longint'(b.tac) * longint'(gain_mem[e])) >>> 8)
                             + longint'(offset_mem[e]);
                        h.cal = 1'b1;
                    end
                    if (h.cal && b.fast && !b.nn && (!latest_seen || h.tm > latest)) begin
                        latest = h.tm;
                        latest_seen = 1'b1;
                    end
                    event_hits.insert(event_hits.size(), h);
                end
                if (b.last) begin
                    o = '{default: '0};
                    if (event_err != 2'd0) begin
                        o.status = event_err;
                        o.last = 1'b1;
                        expected_out.insert(expected_out.size(), o);
                    end else begin
                        n = 0;
                        foreach (event_hits[i]) begin
                            if (hit_survives(event_hits[i])) begin
                                o.status = sht_cut_pkg::ST_PASS;
                                {o.det, o.side, o.strip} = event_hits[i].e;
                                o.tm = event_hits[i].tm[25:0];
                                o.cal = event_hits[i].cal;
                                o.last = 1'b0;
                                expected_out.insert(expected_out.size(), o);
                                n++;
                            end
                        end
                        if (n == 0) begin
                            o = '{default: '0};
                            o.status = sht_cut_pkg::ST_EMPTY;
                            o.last = 1'b1;
                            expected_out.insert(expected_out.size(), o);
                        end else begin
                            expected_out[expected_out.size() - 1].last = 1'b1;
                        end
                    end
                    event_hits.delete();
                    latest = 0;
                    latest_seen = 1'b0;
                    event_err = 2'd0;
                end
            end
            default: ;
        endcase
    endtask

    // driver
    item_t cur;
    int    s_gap = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) predict_item(cur);
            if (!s_tvalid || s_tready) begin
                if (s_gap > 0) begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end else if (pending.size() > 0 && !(pending[0].hold && expected_out.size() > 0)) begin
                    cur = pending.pop_front();
                    s_tdata <= {1'b0, cur.val, cur.sel, cur.nn, cur.fast, cur.guard, cur.tac,
                                cur.strip, cur.side, cur.det};
                    s_tuser <= cur.func;
                    s_tlast <= cur.last;
                    s_tvalid <= 1'b1;
                    s_gap = pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int m_stall = 0;
    always @(posedge aclk) begin
        outcome_t w;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_out.size() == 0) begin
                    report("unexpected beat", m_tdata, 0);
                end else begin
                    w = expected_out.pop_front();
                    if (m_tdata[1:0] != w.status) report("status", m_tdata[1:0], w.status);
                    if (m_tdata[5:2] != w.det) report("detector", m_tdata[5:2], w.det);
                    if (m_tdata[6] != w.side) report("side", m_tdata[6], w.side);
                    if (m_tdata[12:7] != w.strip) report("strip", m_tdata[12:7], w.strip);
                    if (m_tdata[38:13] != w.tm) report("hit_time", m_tdata[38:13], w.tm);
                    if (m_tdata[39] != w.cal) report("calibrated", m_tdata[39], w.cal);
                    if (m_tlast != w.last) report("tlast", m_tlast, w.last);
                end
            end
            if (m_stall > 0) begin
                m_stall--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                m_stall = pick_gap();
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles % 300 == 0) quiet = ($urandom_range(0, 3) == 0);
        if (cycles > 400000) begin
            $display("strip_hit_timing_cut verification failed");
            $finish;
        end
    end

    // stimulus helpers
    function automatic item_t blank(logic [1:0] func, logic [10:0] e);
        item_t b;
        b.func = func;
        {b.det, b.side, b.strip} = e;
        b.tac = 14'($urandom);
        b.guard = 1'($urandom);
        b.fast = 1'($urandom);
        b.nn = 1'($urandom);
        b.last = 1'($urandom);
        b.sel = 3'($urandom);
        b.val = 24'($urandom);
        b.hold = 1'b0;
        return b;
    endfunction

    task automatic add_write(logic [1:0] func, logic [10:0] e, logic [2:0] sel, logic [23:0] val);
        item_t b;
        b = blank(func, e);
        b.sel = sel;
        b.val = val;
        if (func == sht_cut_pkg::FUNC_CAL && sel <= sht_cut_pkg::CAL_OFFSET) gen_cal[e] = 1'b1;
        if (func == sht_cut_pkg::FUNC_CUT && sel <= sht_cut_pkg::CUT_FLAG_DLY) gen_cut[e] = 1'b1;
        pending.insert(pending.size(), b);
    endtask

    task automatic add_calib(logic [10:0] e);
        add_write(sht_cut_pkg::FUNC_CAL, e, sht_cut_pkg::CAL_GAIN,
                  24'($urandom_range(64, 700) | ($urandom & 32'hFF0000)));
        add_write(sht_cut_pkg::FUNC_CAL, e, sht_cut_pkg::CAL_OFFSET,
                  24'($signed($urandom_range(0, 4000)) - 1000));
    endtask

    task automatic add_cuts(logic [10:0] e);
        add_write(sht_cut_pkg::FUNC_CUT, e, sht_cut_pkg::CUT_SHAPING,
                  24'($urandom_range(0, 6000)));
        add_write(sht_cut_pkg::FUNC_CUT, e, sht_cut_pkg::CUT_WINDOW,
                  24'($urandom_range(500, 40000)));
        add_write(sht_cut_pkg::FUNC_CUT, e, sht_cut_pkg::CUT_DISABLE,
                  24'($urandom_range(0, 300)));
        add_write(sht_cut_pkg::FUNC_CUT, e, sht_cut_pkg::CUT_FLAG_EN,
                  24'($urandom_range(0, 300)));
        add_write(sht_cut_pkg::FUNC_CUT, e, sht_cut_pkg::CUT_NOISE,
                  24'($urandom_range(0, 3000)) - 24'd500);
        add_write(sht_cut_pkg::FUNC_CUT, e, sht_cut_pkg::CUT_FLAG_DLY,
                  24'($urandom_range(0, 300)));
    endtask

    task automatic add_hit(logic [10:0] e, bit guard, logic [13:0] tac, bit last);
        item_t b;
        b = blank(sht_cut_pkg::FUNC_HIT, e);
        b.guard = guard;
        b.tac = tac;
        b.last = last;
        pending.insert(pending.size(), b);
    endtask

    function automatic logic [10:0] unwritten_entry();
        logic [10:0] e;
        do e = 11'($urandom); while (gen_cal[e] || gen_cut[e]);
        return e;
    endfunction

    function automatic logic [13:0] rand_tac();
        if ($urandom_range(0, 9) == 0) return 14'd0;
        return 14'($urandom);
    endfunction

    task automatic add_good_event(int nhits);
        logic [10:0] e;
        for (int i = 0; i < nhits; i++) begin
            if ($urandom_range(0, 9) == 0)
                add_hit(11'($urandom), 1'b1, 14'($urandom), i == nhits - 1);
            else begin
                e = full_pool[$urandom_range(0, full_pool.size() - 1)];
                add_hit(e, 1'b0, rand_tac(), i == nhits - 1);
            end
        end
    endtask

    initial begin
        logic [10:0] e;
        item_t       b;
        int          r;
        bit          big_done;
        latest = 0;
        latest_seen = 1'b0;
        event_err = 2'd0;
        big_done = 1'b0;
        foreach (cal_ok[i]) begin
            cal_ok[i] = 1'b0;
            cut_ok[i] = 1'b0;
            gen_cal[i] = 1'b0;
            gen_cut[i] = 1'b0;
        end
        full_pool.insert(full_pool.size(), 11'h000);
        full_pool.insert(full_pool.size(), 11'h7FF);
        while (full_pool.size() < 12) begin
            e = 11'($urandom);
            if (!(e inside {full_pool})) full_pool.insert(full_pool.size(), e);
        end
        while (cal_pool.size() < 3) begin
            e = 11'($urandom);
            if (!(e inside {full_pool}) && !(e inside {cal_pool}))
                cal_pool.insert(cal_pool.size(), e);
        end

        // directed: extremes on entry 0
        add_write(sht_cut_pkg::FUNC_CAL, 11'h000, sht_cut_pkg::CAL_GAIN, 24'hFFFFFF);
        add_write(sht_cut_pkg::FUNC_CAL, 11'h000, sht_cut_pkg::CAL_OFFSET, 24'h7FFFFF);
        for (int s = 0; s < 6; s++)
            add_write(sht_cut_pkg::FUNC_CUT, 11'h000, 3'(s),
                      (s == sht_cut_pkg::CUT_WINDOW) ? 24'h7FFFFF : 24'h800000);
        add_hit(11'h000, 1'b0, 14'h3FFF, 1'b0);
        add_hit(11'h000, 1'b0, 14'h0000, 1'b1);
        add_write(sht_cut_pkg::FUNC_CAL, 11'h000, sht_cut_pkg::CAL_OFFSET, 24'h800000);
        add_hit(11'h000, 1'b0, 14'h3FFF, 1'b1);
        // ignored items
        add_write(sht_cut_pkg::FUNC_CUT, 11'h7FF, 3'd6, 24'h123456);
        add_write(sht_cut_pkg::FUNC_CAL, 11'h7FF, 3'd7, 24'h654321);
        b = blank(2'd3, 11'h7FF);
        pending.insert(pending.size(), b);
        // missing calibration, missing cuts, guard only
        add_hit(unwritten_entry(), 1'b0, 14'd0, 1'b1);
        foreach (cal_pool[i]) add_calib(cal_pool[i]);
        add_hit(cal_pool[0], 1'b0, 14'd100, 1'b1);
        add_hit(11'h7FF, 1'b1, 14'h3FFF, 1'b1);

        foreach (full_pool[i]) begin
            add_calib(full_pool[i]);
            add_cuts(full_pool[i]);
        end
        pending[pending.size() - 1].hold = 1'b1;

        while (pending.size() < 260) begin
            r = $urandom_range(0, 99);
            if (!big_done && pending.size() > 150) begin
                big_done = 1'b1;
                for (int i = 0; i < 67; i++)
                    add_hit(full_pool[$urandom_range(0, 11)], 1'b0, rand_tac(), i == 66);
                pending[pending.size() - 67].hold = 1'b1;
            end else if (r < 68) begin
                r = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 6);
                add_good_event(r);
            end else if (r < 76) begin
                add_good_event(1);
                pending[pending.size() - 1].last = 1'b0;
                add_hit(cal_pool[$urandom_range(0, 2)], 1'b0, rand_tac(), 1'b0);
                add_good_event(1);
            end else if (r < 82) begin
                add_hit(unwritten_entry(), 1'b0, 14'd0, 1'b0);
                add_good_event(2);
            end else if (r < 92) begin
                e = full_pool[$urandom_range(0, 11)];
                if ($urandom_range(0, 1)) add_calib(e);
                else if ($urandom_range(0, 1)) add_cuts(e);
                else add_write(sht_cut_pkg::FUNC_CUT, e, 3'($urandom_range(0, 5)),
                               24'($urandom));
            end else begin
                b = blank($urandom_range(0, 1) ? 2'd3 : sht_cut_pkg::FUNC_CUT, 11'($urandom));
                if (b.func == sht_cut_pkg::FUNC_CUT) b.sel = 3'($urandom_range(6, 7));
                pending.insert(pending.size(), b);
            end
        end

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        wait (pending.size() == 0);
        @(posedge aclk);
        while (s_tvalid || expected_out.size() > 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        if (errors == 0) $display("strip_hit_timing_cut verification clean");
        else $display("strip_hit_timing_cut verification failed");
        $finish;
    end
endmodule

### sim.f
rtl/sht_cut_pkg.sv
rtl/strip_hit_timing_cut.sv
rtl/sht_cut_chk.sv
tb/testbench.sv
